// ----- rtl/core/calibrated_line_position_core_macros.svh -----
// Assertion macros for the calibrated line position core.
// Included by RTL files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef CALIBRATED_LINE_POSITION_CORE_MACROS_SVH
`define CALIBRATED_LINE_POSITION_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication check, disabled in reset
`define CLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Next-cycle implication check, disabled in reset
`define CLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`else

`define CLP_ASSERT(lbl, prop, msg)
`define CLP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/core/clp_pkg.sv -----
// Shared types, constants and helper functions of the calibrated line position core.
// No dependencies; used by every module in rtl/core.
package clp_pkg;

	// Frame geometry
	localparam int CHANNELS    = 8;
	localparam int SAMPLE_BITS = 12;

	// Normalization scale and dark threshold
	localparam int FULL_SCALE = 1000;
	localparam int DARK_LEVEL = 500;

	// Frame command codes
	localparam logic CMD_CAL  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Result field widths
	localparam int POS_W  = 14;
	localparam int DARK_W = 4;

	// Internal widths
	localparam int CH_W       = $clog2(CHANNELS);
	localparam int V_W        = $clog2(FULL_SCALE + 1);
	localparam int WT_W       = $clog2((CHANNELS - 1) * FULL_SCALE + 1);
	localparam int PROD_W     = V_W + WT_W;
	localparam int WSUM_W     = $clog2(FULL_SCALE * FULL_SCALE * CHANNELS * (CHANNELS - 1) / 2 + 1);
	localparam int TOT_W      = $clog2(CHANNELS * FULL_SCALE + 1);
	localparam int DARK_CNT_W = $clog2(CHANNELS + 1);
	localparam int NUM_W      = SAMPLE_BITS + V_W;

	// Divider sizing: quotient bits per operation and datapath widths
	localparam int CH_QB   = V_W;
	localparam int POS_QB  = WT_W;
	localparam int DIV_DW  = (WSUM_W > NUM_W) ? WSUM_W : NUM_W;
	localparam int DIV_VW  = (TOT_W > SAMPLE_BITS) ? TOT_W : SAMPLE_BITS;
	localparam int DIV_QW  = (POS_QB > CH_QB) ? POS_QB : CH_QB;
	localparam int DIV_CW  = $clog2(DIV_QW + 1);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t [CHANNELS-1:0] sample_arr_t;

	// Input transaction payload
	typedef struct packed {
		logic    command;
		sample_t sample_0;
		sample_t sample_1;
		sample_t sample_2;
		sample_t sample_3;
		sample_t sample_4;
		sample_t sample_5;
		sample_t sample_6;
		sample_t sample_7;
	} frame_t;

	// Output transaction payload
	typedef struct packed {
		logic signed [POS_W-1:0]  line_position;
		logic        [DARK_W-1:0] dark_channels;
		logic                     line_seen;
	} result_t;

	// Divider request
	typedef struct packed {
		logic start;
		logic pos_op;
	} div_req_t;

	// Gather the frame samples into a channel-indexed array
	function automatic sample_arr_t frame_samples(frame_t f);
		sample_arr_t a;
		a[0] = f.sample_0;
		a[1] = f.sample_1;
		a[2] = f.sample_2;
		a[3] = f.sample_3;
		a[4] = f.sample_4;
		a[5] = f.sample_5;
		a[6] = f.sample_6;
		a[7] = f.sample_7;
		return a;
	endfunction

	// Position weight of a channel: index times full scale
	function automatic logic [WT_W-1:0] channel_weight(logic [CH_W-1:0] ch);
		logic [WT_W-1:0] w;
		w = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (ch == CH_W'(i)) begin
				w = WT_W'(i * FULL_SCALE);
			end
		end
		return w;
	endfunction

endpackage

// ----- rtl/core/clp_cal.sv -----
// Per-channel calibration bounds: running minimum and maximum of calibrate frames.
// Depends on clp_pkg.
module clp_cal (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd,
	input  clp_pkg::sample_arr_t       samples,
	input  logic [clp_pkg::CH_W-1:0]   rd_ch,
	output clp_pkg::sample_t           rd_min,
	output clp_pkg::sample_t           rd_max
);
	import clp_pkg::*;

	sample_arr_t min_q;
	sample_arr_t max_q;

	// Widen the bounds of every channel on a calibrate transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				min_q[i] <= '1;
				max_q[i] <= '0;
			end
		end else if (upd) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (samples[i] < min_q[i]) begin
					min_q[i] <= samples[i];
				end
				if (samples[i] > max_q[i]) begin
					max_q[i] <= samples[i];
				end
			end
		end
	end

	// Bounds of the channel under work
	assign rd_min = min_q[rd_ch];
	assign rd_max = max_q[rd_ch];

endmodule

// ----- rtl/core/clp_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on clp_pkg; caller guarantees dividend < divisor << quotient bits.
module clp_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  clp_pkg::div_req_t            req,
	input  logic [clp_pkg::DIV_DW-1:0]   dividend,
	input  logic [clp_pkg::DIV_VW-1:0]   divisor,
	output logic                         done,
	output logic [clp_pkg::DIV_QW-1:0]   quotient
);
	import clp_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_VW-1:0] rem_q;
	logic [DIV_DW-1:0] dq_q;
	logic [DIV_QW-1:0] quo_q;
	logic [DIV_VW-1:0] div_q;

	logic [DIV_VW:0]   trial;
	logic [DIV_VW:0]   diff;
	logic              fits;
	logic [DIV_VW-1:0] ld_rem;
	logic [DIV_DW-1:0] ld_dq;
	logic [DIV_CW-1:0] ld_cnt;

	// Operand alignment: partial remainder starts with the bits above the quotient field
	always_comb begin
		if (req.pos_op) begin
			ld_rem = DIV_VW'(dividend >> POS_QB);
			ld_dq  = dividend << (DIV_DW - POS_QB);
			ld_cnt = DIV_CW'(POS_QB);
		end else begin
			ld_rem = DIV_VW'(dividend >> CH_QB);
			ld_dq  = dividend << (DIV_DW - CH_QB);
			ld_cnt = DIV_CW'(CH_QB);
		end
	end

	// One restoring step
	assign trial = {rem_q, dq_q[DIV_DW-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ld_cnt;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CW'(1);
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= ld_rem;
			dq_q  <= ld_dq;
			quo_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
			dq_q  <= dq_q << 1;
			quo_q <= {quo_q[DIV_QW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/core/calibrated_line_position_core.sv -----
// Calibrated line position core: top level, sequencer and accumulators.
// Depends on clp_pkg, clp_cal, clp_div and calibrated_line_position_core_macros.svh.
//
// A calibrate transaction (command 0) widens the per-channel minimum and maximum in the
// cycle it is accepted and gives no result; the core is ready again the next cycle. A read
// transaction (command 1) walks the channels one at a time through S_CHAN, S_CLASS and
// S_ACC. A channel whose value follows without division (equal bounds, opposite or zero
// signs, saturation) skips S_DIV; any other waits there on the shared restoring divider
// (10 quotient bits). When any channel is dark, the position is then one more pass
// through the same divider (13 quotient bits), the divider being the limiting unit, and
// frame_ready stays low from acceptance until the read's result has been taken.
`include "calibrated_line_position_core_macros.svh"

module calibrated_line_position_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	output logic              frame_ready,
	input  clp_pkg::frame_t   frame,
	output logic              result_valid,
	input  logic              result_ready,
	output clp_pkg::result_t  result
);
	import clp_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CHAN  = 8'b0000_0010,
		S_CLASS = 8'b0000_0100,
		S_DIV   = 8'b0000_1000,
		S_ACC   = 8'b0001_0000,
		S_FINAL = 8'b0010_0000,
		S_FWAIT = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t                state_q;
	state_t                state_d;
	logic [CH_W-1:0]       ch_q;

	sample_arr_t           samples_q;
	logic                  eq_q;
	logic                  agree_q;
	logic [NUM_W-1:0]      num_q;
	sample_t               den_q;
	sample_t               raw_q;
	logic [V_W-1:0]        v_q;
	logic [WSUM_W-1:0]     wsum_q;
	logic [TOT_W-1:0]      tot_q;
	logic [DARK_CNT_W-1:0] dark_q;
	result_t               result_q;

	logic                  frame_take;
	sample_t               chan_s;
	sample_t               cal_min;
	sample_t               cal_max;
	sample_t               mag_n;
	sample_t               mag_d;
	logic                  cls_sat;
	logic                  cls_div;
	logic [V_W-1:0]        cls_v;
	logic [V_W-1:0]        div_v;
	logic [PROD_W-1:0]     prod;
	logic                  last_ch;

	div_req_t              div_req;
	logic [DIV_DW-1:0]     div_dividend;
	logic [DIV_VW-1:0]     div_divisor;
	logic                  div_done;
	logic [DIV_QW-1:0]     div_quo;

	assign frame_take = frame_valid && frame_ready;

	// Calibration bounds
	clp_cal u_cal (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (frame_take && (frame.command == CMD_CAL)),
		.samples (frame_samples(frame)),
		.rd_ch   (ch_q),
		.rd_min  (cal_min),
		.rd_max  (cal_max)
	);

	// Shared divider: channel normalization and final centroid
	clp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Channel operands: magnitudes of (s - min) and (max - min)
	assign chan_s = samples_q[ch_q];
	assign mag_n  = (chan_s >= cal_min) ? (chan_s - cal_min) : (cal_min - chan_s);
	assign mag_d  = (cal_max >= cal_min) ? (cal_max - cal_min) : (cal_min - cal_max);

	// Classification: quotient of 1024 or more clamps to full scale
	always_comb begin
		cls_sat = num_q >= {den_q, {CH_QB{1'b0}}};
		cls_div = !eq_q && agree_q && !cls_sat;
		if (eq_q) begin
			cls_v = (raw_q > FULL_SCALE) ? V_W'(FULL_SCALE) : V_W'(raw_q);
		end else if (!agree_q) begin
			cls_v = '0;
		end else begin
			cls_v = V_W'(FULL_SCALE);
		end
		div_v = (div_quo > FULL_SCALE) ? V_W'(FULL_SCALE) : V_W'(div_quo);
	end

	// Divider request and operand selection
	always_comb begin
		div_req.start  = ((state_q == S_CLASS) && cls_div) ||
			((state_q == S_FINAL) && (dark_q != '0));
		div_req.pos_op = (state_q == S_FINAL);
		if (state_q == S_FINAL) begin
			div_dividend = DIV_DW'(wsum_q);
			div_divisor  = DIV_VW'(tot_q);
		end else begin
			div_dividend = DIV_DW'(num_q);
			div_divisor  = DIV_VW'(den_q);
		end
	end

	assign prod    = PROD_W'(v_q) * PROD_W'(channel_weight(ch_q));
	assign last_ch = (ch_q == CH_W'(CHANNELS - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (frame_take && (frame.command == CMD_READ)) begin
					state_d = S_CHAN;
				end
			end
			S_CHAN: begin
				state_d = S_CLASS;
			end
			S_CLASS: begin
				state_d = cls_div ? S_DIV : S_ACC;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				state_d = last_ch ? S_FINAL : S_CHAN;
			end
			S_FINAL: begin
				state_d = (dark_q != '0) ? S_FWAIT : S_OUT;
			end
			S_FWAIT: begin
				if (div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (result_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			if (frame_take) begin
				ch_q <= '0;
			end else if ((state_q == S_ACC) && !last_ch) begin
				ch_q <= ch_q + CH_W'(1);
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (frame_take && (frame.command == CMD_READ)) begin
			samples_q <= frame_samples(frame);
			wsum_q    <= '0;
			tot_q     <= '0;
			dark_q    <= '0;
		end
		if (state_q == S_CHAN) begin
			eq_q    <= (cal_min == cal_max);
			agree_q <= ((chan_s > cal_min) && (cal_max > cal_min)) ||
				((chan_s < cal_min) && (cal_max < cal_min));
			num_q   <= NUM_W'(mag_n) * NUM_W'(FULL_SCALE);
			den_q   <= mag_d;
			raw_q   <= chan_s;
		end
		if (state_q == S_CLASS) begin
			v_q <= cls_v;
		end
		if ((state_q == S_DIV) && div_done) begin
			v_q <= div_v;
		end
		if (state_q == S_ACC) begin
			wsum_q <= wsum_q + WSUM_W'(prod);
			tot_q  <= tot_q + TOT_W'(v_q);
			if (v_q > DARK_LEVEL) begin
				dark_q <= dark_q + DARK_CNT_W'(1);
			end
		end
		if ((state_q == S_FINAL) && (dark_q == '0)) begin
			result_q.line_position <= '1;
			result_q.dark_channels <= '0;
			result_q.line_seen     <= 1'b0;
		end
		if ((state_q == S_FWAIT) && div_done) begin
			result_q.line_position <= $signed(POS_W'(div_quo));
			result_q.dark_channels <= DARK_W'(dark_q);
			result_q.line_seen     <= 1'b1;
		end
	end

	assign frame_ready  = (state_q == S_IDLE);
	assign result_valid = (state_q == S_OUT);
	assign result       = result_q;

	// Checks
	`CLP_ASSERT(a_done_when_waiting,
		div_done |-> ((state_q == S_DIV) || (state_q == S_FWAIT)),
		"divider finished outside a wait state")
	`CLP_ASSERT(a_value_in_range, (state_q == S_ACC) |-> (v_q <= FULL_SCALE),
		"normalized value above full scale")
	`CLP_ASSERT(a_seen_matches_count,
		result_valid |-> (result.line_seen == (result.dark_channels != '0)),
		"line_seen disagrees with dark count")
	`CLP_ASSERT(a_lost_position,
		(result_valid && !result.line_seen) |-> (&result.line_position),
		"lost line without position of -1")
	`CLP_ASSERT_NEXT(a_read_blocks, (frame_take && (frame.command == CMD_READ)),
		!frame_ready, "read transaction did not occupy the core")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for calibrated_line_position_core: directed frames, then random frames.
// Depends on clp_pkg and core RTL; expected results from typed rows or an in-bench estimator.
`timescale 1ns / 100ps

module tb_top;
	import clp_pkg::*;

	localparam int RANDOM_ITEMS  = 1830;
	localparam int HOLDOFF_AT    = 60;
	localparam int HOLDOFF_LEN   = 400;
	localparam int DRAIN_AT      = 900;
	localparam int DRAIN_CYCLES  = 200;

	localparam result_t LINE_LOST = '{line_position: '1, dark_channels: '0, line_seen: 1'b0};

	typedef struct {
		frame_t  f;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    frame_valid = 1'b0;
	logic    frame_ready;
	frame_t  frame = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// Estimator copy of the calibration bounds
	sample_t cal_lo [CHANNELS];
	sample_t cal_hi [CHANNELS];

	result_t  expected_results [$];
	dir_row_t directed_rows [$];
	int       mismatches = 0;
	int       results_seen = 0;
	int       random_sent = 0;
	int       holdoff_left = 0;
	bit       holdoff_done = 1'b0;

	calibrated_line_position_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic frame_t make_frame(logic cmd, sample_t s0, sample_t s1, sample_t s2,
			sample_t s3, sample_t s4, sample_t s5, sample_t s6, sample_t s7);
		frame_t f;
		f.command  = cmd;
		f.sample_0 = s0;
		f.sample_1 = s1;
		f.sample_2 = s2;
		f.sample_3 = s3;
		f.sample_4 = s4;
		f.sample_5 = s5;
		f.sample_6 = s6;
		f.sample_7 = s7;
		return f;
	endfunction

	function automatic frame_t uniform_frame(logic cmd, sample_t s);
		return make_frame(cmd, s, s, s, s, s, s, s, s);
	endfunction

	function automatic result_t line_at(int pos, int dark);
		result_t r;
		r.line_position = POS_W'(pos);
		r.dark_channels = DARK_W'(dark);
		r.line_seen     = 1'b1;
		return r;
	endfunction

	function automatic sample_t clip_sample(int x);
		if (x < 0)
			return '0;
		if (x > 4095)
			return '1;
		return sample_t'(x);
	endfunction

	// Line estimator: widens bounds on calibrate, returns 1 with a result on read
	function automatic bit estimate_line(input frame_t f, output result_t r);
		sample_t s [CHANNELS];
		longint v, lo_v, hi_v, weighted, total;
		int dark;
		s[0] = f.sample_0;
		s[1] = f.sample_1;
		s[2] = f.sample_2;
		s[3] = f.sample_3;
		s[4] = f.sample_4;
		s[5] = f.sample_5;
		s[6] = f.sample_6;
		s[7] = f.sample_7;
		r = '0;
		if (f.command == CMD_CAL) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (s[i] < cal_lo[i])
					cal_lo[i] = s[i];
				if (s[i] > cal_hi[i])
					cal_hi[i] = s[i];
			end
			return 1'b0;
		end
		weighted = 0;
		total = 0;
		dark = 0;
		for (int i = 0; i < CHANNELS; i++) begin
			v = s[i];
			lo_v = cal_lo[i];
			hi_v = cal_hi[i];
			// signed division truncating toward zero; an inverted range gives a negative divisor
			if (lo_v != hi_v)
				v = ((v - lo_v) * FULL_SCALE) / (hi_v - lo_v);
			if (v < 0)
				v = 0;
			if (v > FULL_SCALE)
				v = FULL_SCALE;
			if (v > DARK_LEVEL)
				dark++;
			weighted += v * i * FULL_SCALE;
			total += v;
		end
		if (dark == 0 || total == 0) begin
			r = LINE_LOST;
		end else begin
			r.line_position = POS_W'(weighted / total);
			r.dark_channels = DARK_W'(dark);
			r.line_seen     = 1'b1;
		end
		return 1'b1;
	endfunction

	// Random frame shaped around the current bounds
	function automatic frame_t random_frame();
		sample_t s [CHANNELS];
		logic cmd;
		bit light;
		int lo, hi, mid, pick;
		cmd = ($urandom_range(99) < 20) ? CMD_CAL : CMD_READ;
		light = ($urandom_range(99) < 15);
		for (int i = 0; i < CHANNELS; i++) begin
			lo = cal_lo[i];
			hi = cal_hi[i];
			if (hi < lo)
				hi = lo;
			mid = lo + (hi - lo) / 2;
			pick = $urandom_range(99);
			if (cmd == CMD_CAL) begin
				// mostly creep the bounds outward, rarely jump anywhere
				if (pick < 2)
					s[i] = sample_t'($urandom_range(4095));
				else
					s[i] = clip_sample(lo - 3 + int'($urandom_range(hi - lo + 6)));
			end else if (light) begin
				s[i] = clip_sample(int'($urandom_range(mid)));
			end else if (pick < 40) begin
				s[i] = sample_t'($urandom_range(4095));
			end else if (pick < 75) begin
				s[i] = clip_sample(lo + int'($urandom_range(hi - lo)));
			end else begin
				s[i] = clip_sample(mid - 4 + int'($urandom_range(8)));
			end
		end
		return make_frame(cmd, s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7]);
	endfunction

	task automatic add_row(frame_t f, bit typed, result_t want);
		dir_row_t row;
		row.f = f;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// Offer one frame from a falling edge; returns at the falling edge after acceptance
	task automatic send_frame(frame_t f, bit typed, result_t want, bit calm);
		result_t est;
		bit has_result;
		while (!calm && $urandom_range(99) < 9) begin
			frame_valid <= 1'b0;
			@(negedge clk);
		end
		frame <= f;
		frame_valid <= 1'b1;
		@(posedge clk);
		while (!frame_ready)
			@(posedge clk);
		has_result = estimate_line(f, est);
		if (has_result)
			expected_results.push_back(typed ? want : est);
		@(negedge clk);
	endtask

	task automatic report_mismatch(string what, result_t want, result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch (%s): expected pos %0d dark %0d seen %0d, %s %0d %s %0d %s %0d",
				$realtime, what, want.line_position, want.dark_channels, want.line_seen,
				"got pos", got.line_position, "dark", got.dark_channels,
				"seen", got.line_seen);
	endtask

	// Result checker
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen = results_seen + 1;
			if (expected_results.size() == 0) begin
				report_mismatch("no transaction expected", '0, result);
			end else begin
				want = expected_results.pop_front();
				if (result.line_position !== want.line_position)
					report_mismatch("line_position", want, result);
				else if (result.dark_channels !== want.dark_channels)
					report_mismatch("dark_channels", want, result);
				else if (result.line_seen !== want.line_seen)
					report_mismatch("line_seen", want, result);
			end
		end
	end

	// Receiver: random back-pressure, one long hold-off, and a quiet window
	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
			result_ready <= 1'b0;
		end else if (!holdoff_done && results_seen == HOLDOFF_AT) begin
			holdoff_done <= 1'b1;
			holdoff_left <= HOLDOFF_LEN;
			result_ready <= 1'b0;
		end else if (results_seen >= 500 && results_seen < 800) begin
			result_ready <= 1'b1;
		end else begin
			result_ready <= ($urandom_range(99) >= 9);
		end
	end

	// Stimulus
	initial begin
		for (int i = 0; i < CHANNELS; i++) begin
			cal_lo[i] = '1;
			cal_hi[i] = '0;
		end

		// Uncalibrated channels: inverted range
		add_row(uniform_frame(CMD_READ, 12'd4095), 1'b1, LINE_LOST);
		add_row(uniform_frame(CMD_READ, 12'd0), 1'b0, '0);
		add_row(make_frame(CMD_READ, 0, 4095, 0, 4095, 2048, 1, 4094, 100), 1'b0, '0);
		// Equal bounds: raw sample, clamped
		add_row(uniform_frame(CMD_CAL, 12'd1000), 1'b0, '0);
		add_row(uniform_frame(CMD_READ, 12'd500), 1'b1, LINE_LOST);
		add_row(uniform_frame(CMD_READ, 12'd501), 1'b1, line_at(3500, 8));
		add_row(make_frame(CMD_READ, 4095, 0, 0, 0, 0, 0, 0, 0), 1'b1, line_at(0, 1));
		add_row(make_frame(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 4095), 1'b1, line_at(7000, 1));
		// Bounds 1000..3000: below, above and at the dark threshold
		add_row(uniform_frame(CMD_CAL, 12'd3000), 1'b0, '0);
		add_row(uniform_frame(CMD_READ, 12'd0), 1'b1, LINE_LOST);
		add_row(uniform_frame(CMD_READ, 12'd4095), 1'b1, line_at(3500, 8));
		add_row(uniform_frame(CMD_READ, 12'd2000), 1'b1, LINE_LOST);
		add_row(uniform_frame(CMD_READ, 12'd2001), 1'b1, LINE_LOST);
		add_row(uniform_frame(CMD_READ, 12'd2002), 1'b1, line_at(3500, 8));
		add_row(make_frame(CMD_READ, 3000, 1000, 1000, 1000, 1000, 1000, 1000, 1000),
			1'b1, line_at(0, 1));
		add_row(make_frame(CMD_READ, 1000, 1000, 1000, 1000, 1000, 2002, 1000, 1000),
			1'b1, line_at(5000, 1));
		add_row(uniform_frame(CMD_READ, 12'd3000), 1'b1, line_at(3500, 8));
		add_row(make_frame(CMD_READ, 1000, 1000, 1000, 3000, 3000, 1000, 1000, 1000),
			1'b0, '0);
		add_row(make_frame(CMD_READ, 1000, 1250, 1500, 1750, 2000, 2250, 2500, 2750),
			1'b0, '0);
		add_row(make_frame(CMD_READ, 0, 4095, 0, 4095, 0, 4095, 0, 4095), 1'b0, '0);
		add_row(make_frame(CMD_CAL, 'hAAA, 'h555, 'hAAA, 'h555, 'hAAA, 'h555, 'hAAA, 'h555),
			1'b0, '0);
		add_row(make_frame(CMD_READ, 'h555, 'hAAA, 'h555, 'hAAA, 'h555, 'hAAA, 'h555, 'hAAA),
			1'b0, '0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[k])
			send_frame(directed_rows[k].f, directed_rows[k].typed, directed_rows[k].want, 1'b0);

		for (random_sent = 0; random_sent < RANDOM_ITEMS; random_sent++) begin
			if (random_sent == DRAIN_AT) begin
				// let the core drain completely before going on
				frame_valid <= 1'b0;
				@(negedge clk);
				while (expected_results.size() != 0)
					@(negedge clk);
			end
			send_frame(random_frame(), 1'b0, '0, random_sent >= 300 && random_sent < 700);
		end
		frame_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
